### src/dpalu_pkg.sv
package dpalu_pkg;

  // shifter operand modes
  localparam logic [1:0] MODE_PASS  = 2'd0;  // Rm or imm through, carry = C
  localparam logic [1:0] MODE_SHIFT = 2'd1;  // shift by amt in 1..255
  localparam logic [1:0] MODE_RRX   = 2'd2;  // rotate right extended

  // shift types, instr[6:5]
  localparam logic [1:0] SH_LSL = 2'd0;
  localparam logic [1:0] SH_LSR = 2'd1;
  localparam logic [1:0] SH_ASR = 2'd2;
  localparam logic [1:0] SH_ROR = 2'd3;

  // opcodes, instr[24:21]
  localparam logic [3:0] OP_AND = 4'd0;
  localparam logic [3:0] OP_EOR = 4'd1;
  localparam logic [3:0] OP_SUB = 4'd2;
  localparam logic [3:0] OP_RSB = 4'd3;
  localparam logic [3:0] OP_ADD = 4'd4;
  localparam logic [3:0] OP_ADC = 4'd5;
  localparam logic [3:0] OP_SBC = 4'd6;
  localparam logic [3:0] OP_RSC = 4'd7;
  localparam logic [3:0] OP_TST = 4'd8;
  localparam logic [3:0] OP_TEQ = 4'd9;
  localparam logic [3:0] OP_CMP = 4'd10;
  localparam logic [3:0] OP_CMN = 4'd11;
  localparam logic [3:0] OP_ORR = 4'd12;
  localparam logic [3:0] OP_MOV = 4'd13;
  localparam logic [3:0] OP_BIC = 4'd14;
  localparam logic [3:0] OP_MVN = 4'd15;

  // condition codes, instr[31:28]
  localparam logic [3:0] CC_EQ = 4'd0;
  localparam logic [3:0] CC_NE = 4'd1;
  localparam logic [3:0] CC_CS = 4'd2;
  localparam logic [3:0] CC_CC = 4'd3;
  localparam logic [3:0] CC_MI = 4'd4;
  localparam logic [3:0] CC_PL = 4'd5;
  localparam logic [3:0] CC_VS = 4'd6;
  localparam logic [3:0] CC_VC = 4'd7;
  localparam logic [3:0] CC_HI = 4'd8;
  localparam logic [3:0] CC_LS = 4'd9;
  localparam logic [3:0] CC_GE = 4'd10;
  localparam logic [3:0] CC_LT = 4'd11;
  localparam logic [3:0] CC_GT = 4'd12;
  localparam logic [3:0] CC_LE = 4'd13;
  localparam logic [3:0] CC_AL = 4'd14;
  localparam logic [3:0] CC_NV = 4'd15;

  localparam logic [3:0] REG_PC = 4'd15;

  // instruction context carried down the pipe
  typedef struct packed {
    logic       passed;
    logic [3:0] op;
    logic       s;
    logic [3:0] rd;
    logic [3:0] flags;   // N Z C V
  } ctl_t;

  // resolved shifter request
  typedef struct packed {
    logic [1:0] mode;
    logic [1:0] typ;
    logic [7:0] amt;
  } shf_t;

  // result side status
  typedef struct packed {
    logic       wres;
    logic [3:0] rd;
    logic [3:0] fout;
    logic       wflags;
    logic       restore;
    logic       passed;
  } sts_t;

endpackage

### src/dpalu_in_if.sv
interface dpalu_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] instr_word;
  logic [31:0] first_operand;
  logic [31:0] shift_source;
  logic [31:0] shift_amount_reg;
  logic [3:0]  flags_in;

  modport source (
    output valid, instr_word, first_operand, shift_source, shift_amount_reg, flags_in,
    input  ready
  );
  modport sink (
    input  valid, instr_word, first_operand, shift_source, shift_amount_reg, flags_in,
    output ready
  );
endinterface

### src/dpalu_out_if.sv
interface dpalu_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_value;
  logic        write_result;
  logic [3:0]  dest_index;
  logic [3:0]  flags_out;
  logic        write_flags;
  logic        restore_status;
  logic        cond_passed;

  modport source (
    output valid, result_value, write_result, dest_index, flags_out, write_flags,
           restore_status, cond_passed,
    input  ready
  );
  modport sink (
    input  valid, result_value, write_result, dest_index, flags_out, write_flags,
           restore_status, cond_passed,
    output ready
  );
endinterface

### src/dpalu_decode.sv
module dpalu_decode (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               in_valid,
  input  logic [31:0]        instr_word,
  input  logic [31:0]        first_operand,
  input  logic [31:0]        shift_source,
  input  logic [31:0]        shift_amount_reg,
  input  logic [3:0]         flags_in,
  output logic               vld_r,
  output dpalu_pkg::ctl_t    ctl_r,
  output dpalu_pkg::shf_t    shf_r,
  output logic [31:0]        rn_r,
  output logic [31:0]        src_r
);
  import dpalu_pkg::*;

  logic        fn, fz, fc, fv;
  logic        passed;
  logic [4:0]  imm_sh;
  ctl_t        ctl_nxt;
  shf_t        shf_nxt;
  logic [31:0] src_nxt;

  assign fn = flags_in[3];
  assign fz = flags_in[2];
  assign fc = flags_in[1];
  assign fv = flags_in[0];
  assign imm_sh = instr_word[11:7];

  always_comb begin
    unique case (instr_word[31:28])
      CC_EQ: passed = fz;
      CC_NE: passed = !fz;
      CC_CS: passed = fc;
      CC_CC: passed = !fc;
      CC_MI: passed = fn;
      CC_PL: passed = !fn;
      CC_VS: passed = fv;
      CC_VC: passed = !fv;
      CC_HI: passed = fc && !fz;
      CC_LS: passed = !fc || fz;
      CC_GE: passed = (fn == fv);
      CC_LT: passed = (fn != fv);
      CC_GT: passed = !fz && (fn == fv);
      CC_LE: passed = fz || (fn != fv);
      CC_AL: passed = 1'b1;
      CC_NV: passed = 1'b0;
      default: passed = 1'b0;
    endcase
  end

  always_comb begin
    ctl_nxt.passed = passed;
    ctl_nxt.op     = instr_word[24:21];
    ctl_nxt.s      = instr_word[20];
    ctl_nxt.rd     = instr_word[15:12];
    ctl_nxt.flags  = flags_in;

    shf_nxt.typ  = instr_word[6:5];
    shf_nxt.amt  = 8'd0;
    shf_nxt.mode = MODE_SHIFT;
    src_nxt      = shift_source;

    priority if (instr_word[25]) begin
      // rotated immediate; rotate by zero keeps C
      src_nxt      = {24'd0, instr_word[7:0]};
      shf_nxt.typ  = SH_ROR;
      shf_nxt.amt  = {3'd0, instr_word[11:8], 1'b0};
      shf_nxt.mode = (instr_word[11:8] == 4'd0) ? MODE_PASS : MODE_SHIFT;
    end else if (instr_word[4]) begin
      // register shift, bit 7 ignored
      shf_nxt.amt  = shift_amount_reg[7:0];
      shf_nxt.mode = (shift_amount_reg[7:0] == 8'd0) ? MODE_PASS : MODE_SHIFT;
    end else if (imm_sh != 5'd0) begin
      shf_nxt.amt = {3'd0, imm_sh};
    end else begin
      // immediate shift by zero: LSL passes, LSR/ASR mean 32, ROR is RRX
      unique case (instr_word[6:5])
        SH_LSL:  shf_nxt.mode = MODE_PASS;
        SH_ROR:  shf_nxt.mode = MODE_RRX;
        default: shf_nxt.amt  = 8'd32;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl_r <= ctl_nxt;
      shf_r <= shf_nxt;
      rn_r  <= first_operand;
      src_r <= src_nxt;
    end
  end

endmodule

### src/dpalu_shifter.sv
module dpalu_shifter (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic            vld,
  input  dpalu_pkg::ctl_t ctl,
  input  dpalu_pkg::shf_t shf,
  input  logic [31:0]     rn,
  input  logic [31:0]     src,
  output logic            vld_r,
  output dpalu_pkg::ctl_t ctl_r,
  output logic [31:0]     rn_r,
  output logic [31:0]     opnd_r,
  output logic            sco_r
);
  import dpalu_pkg::*;

  logic        cin;
  logic [4:0]  r;
  logic        big;
  logic        eq32;
  logic [4:0]  idx_r;
  logic [4:0]  idx_l;
  logic [63:0] dbl;
  logic [31:0] opnd_nxt;
  logic        sco_nxt;

  assign cin   = ctl.flags[1];
  assign r     = shf.amt[4:0];
  assign big   = (shf.amt[7:5] != 3'd0);
  assign eq32  = (shf.amt == 8'd32);
  assign idx_r = r - 5'd1;
  assign idx_l = 5'd0 - r;
  assign dbl   = {src, src} >> r;

  always_comb begin
    opnd_nxt = src;
    sco_nxt  = cin;
    unique case (shf.mode)
      MODE_PASS: begin
        opnd_nxt = src;
        sco_nxt  = cin;
      end
      MODE_RRX: begin
        opnd_nxt = {cin, src[31:1]};
        sco_nxt  = src[0];
      end
      MODE_SHIFT: begin
        unique case (shf.typ)
          SH_LSL: begin
            opnd_nxt = big ? 32'd0 : (src << r);
            sco_nxt  = big ? (eq32 & src[0]) : src[idx_l];
          end
          SH_LSR: begin
            opnd_nxt = big ? 32'd0 : (src >> r);
            sco_nxt  = big ? (eq32 & src[31]) : src[idx_r];
          end
          SH_ASR: begin
            opnd_nxt = big ? {32{src[31]}} : 32'($signed(src) >>> r);
            sco_nxt  = big ? src[31] : src[idx_r];
          end
          SH_ROR: begin
            // multiple of 32 leaves Rm, carry from bit 31
            opnd_nxt = dbl[31:0];
            sco_nxt  = (r == 5'd0) ? src[31] : src[idx_r];
          end
          default: begin
            opnd_nxt = src;
            sco_nxt  = cin;
          end
        endcase
      end
      default: begin
        opnd_nxt = src;
        sco_nxt  = cin;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl_r  <= ctl;
      rn_r   <= rn;
      opnd_r <= opnd_nxt;
      sco_r  <= sco_nxt;
    end
  end

endmodule

### src/dpalu_exec.sv
module dpalu_exec (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic            vld,
  input  dpalu_pkg::ctl_t ctl,
  input  logic [31:0]     rn,
  input  logic [31:0]     opnd,
  input  logic            sco,
  output logic            vld_r,
  output logic [31:0]     res_r,
  output dpalu_pkg::sts_t sts_r
);
  import dpalu_pkg::*;

  logic        cin;
  logic        logical;
  logic [31:0] x, y, lres;
  logic        k;
  logic [32:0] sum;
  logic [31:0] res_nxt;
  logic        c, v;
  logic        writes, wres, restore, wflags;
  sts_t        sts_nxt;

  assign cin = ctl.flags[1];

  always_comb begin
    logical = 1'b1;
    lres    = 32'd0;
    x       = rn;
    y       = opnd;
    k       = 1'b0;
    unique case (ctl.op)
      OP_AND, OP_TST: lres = rn & opnd;
      OP_EOR, OP_TEQ: lres = rn ^ opnd;
      OP_ORR:         lres = rn | opnd;
      OP_MOV:         lres = opnd;
      OP_BIC:         lres = rn & ~opnd;
      OP_MVN:         lres = ~opnd;
      OP_SUB, OP_CMP: begin logical = 1'b0; x = rn;   y = ~opnd; k = 1'b1; end
      OP_RSB:         begin logical = 1'b0; x = opnd; y = ~rn;   k = 1'b1; end
      OP_ADD, OP_CMN: begin logical = 1'b0; x = rn;   y = opnd;  k = 1'b0; end
      OP_ADC:         begin logical = 1'b0; x = rn;   y = opnd;  k = cin;  end
      OP_SBC:         begin logical = 1'b0; x = rn;   y = ~opnd; k = cin;  end
      OP_RSC:         begin logical = 1'b0; x = opnd; y = ~rn;   k = cin;  end
      default:        lres = 32'd0;
    endcase
  end

  assign sum     = {1'b0, x} + {1'b0, y} + {32'd0, k};
  assign res_nxt = logical ? lres : sum[31:0];
  assign c       = logical ? sco : sum[32];
  assign v       = logical ? ctl.flags[0]
                           : ((x[31] ^ sum[31]) & (y[31] ^ sum[31]));

  // test ops never write Rd
  assign writes  = (ctl.op[3:2] != 2'b10);
  assign wres    = ctl.passed && writes;
  assign restore = wres && ctl.s && (ctl.rd == REG_PC);
  assign wflags  = ctl.passed && ctl.s && !restore;

  always_comb begin
    sts_nxt.wres    = wres;
    sts_nxt.rd      = ctl.rd;
    sts_nxt.fout    = wflags ? {res_nxt[31], (res_nxt == 32'd0), c, v} : ctl.flags;
    sts_nxt.wflags  = wflags;
    sts_nxt.restore = restore;
    sts_nxt.passed  = ctl.passed;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
      sts_r <= sts_nxt;
    end
  end

endmodule

### src/arm_data_processing_alu.sv
// ARMv5 data-processing execute unit: condition check, barrel shifter, ALU.
//
// in_ch  : one word per instruction: instr_word plus Rn, Rm, Rs values and
//          the current NZCV flags. Taken when valid and ready are both high.
// out_ch : one word per instruction with the result for Rd, write enables,
//          new flags, the status restore request and the condition outcome.
//
// Pipeline: decode/condition -> barrel shifter -> ALU and flags. Each stage
// is one register: a taken word moves from the decode register through the
// shifter register into the ALU register. A new word can be taken every
// cycle (throughput 1 per clock) unless a stall fills every stage.
// The ALU stage register is the output register.
//
// Stall: when out_ch.ready is low the last stage holds; earlier stages keep
// moving into empty slots, so up to three words sit inside. in_ch.ready
// drops only once every stage is full. Nothing is dropped or repeated.
//
// Reset (rst_n low, synchronous) empties the pipe: all valid bits clear.
// There is no architectural state.
module arm_data_processing_alu (
  input logic         clk,
  input logic         rst_n,
  dpalu_in_if.sink    in_ch,
  dpalu_out_if.source out_ch
);
  import dpalu_pkg::*;

  logic        dec_vld, shf_vld, exe_vld;
  logic        adv1, adv2, adv3;
  ctl_t        dec_ctl, shf_ctl;
  shf_t        dec_shf;
  logic [31:0] dec_rn, dec_src;
  logic [31:0] shf_rn, shf_opnd;
  logic        shf_sco;
  logic [31:0] exe_res;
  sts_t        exe_sts;

  // a stage moves when it is empty or the one after it moves
  assign adv3 = !exe_vld || out_ch.ready;
  assign adv2 = !shf_vld || adv3;
  assign adv1 = !dec_vld || adv2;

  assign in_ch.ready = adv1;

  dpalu_decode u_decode (
    .clk              (clk),
    .rst_n            (rst_n),
    .adv              (adv1),
    .in_valid         (in_ch.valid),
    .instr_word       (in_ch.instr_word),
    .first_operand    (in_ch.first_operand),
    .shift_source     (in_ch.shift_source),
    .shift_amount_reg (in_ch.shift_amount_reg),
    .flags_in         (in_ch.flags_in),
    .vld_r            (dec_vld),
    .ctl_r            (dec_ctl),
    .shf_r            (dec_shf),
    .rn_r             (dec_rn),
    .src_r            (dec_src)
  );

  dpalu_shifter u_shifter (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv2),
    .vld    (dec_vld),
    .ctl    (dec_ctl),
    .shf    (dec_shf),
    .rn     (dec_rn),
    .src    (dec_src),
    .vld_r  (shf_vld),
    .ctl_r  (shf_ctl),
    .rn_r   (shf_rn),
    .opnd_r (shf_opnd),
    .sco_r  (shf_sco)
  );

  dpalu_exec u_exec (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv3),
    .vld   (shf_vld),
    .ctl   (shf_ctl),
    .rn    (shf_rn),
    .opnd  (shf_opnd),
    .sco   (shf_sco),
    .vld_r (exe_vld),
    .res_r (exe_res),
    .sts_r (exe_sts)
  );

  assign out_ch.valid          = exe_vld;
  assign out_ch.result_value   = exe_res;
  assign out_ch.write_result   = exe_sts.wres;
  assign out_ch.dest_index     = exe_sts.rd;
  assign out_ch.flags_out      = exe_sts.fout;
  assign out_ch.write_flags    = exe_sts.wflags;
  assign out_ch.restore_status = exe_sts.restore;
  assign out_ch.cond_passed    = exe_sts.passed;

  // flag write and status restore never go out together
  a_wflags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    exe_vld && exe_sts.wflags |-> exe_sts.passed && !exe_sts.restore)
    else $error("flag write with failed condition or restore");

  a_restore_pc: assert property (@(posedge clk) disable iff (!rst_n)
    exe_vld && exe_sts.restore |-> exe_sts.wres && (exe_sts.rd == REG_PC))
    else $error("restore without write to pc");

  a_take_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> dec_vld)
    else $error("taken word not in decode stage");

  a_dec_hold: assert property (@(posedge clk) disable iff (!rst_n)
    dec_vld && !adv2 |=> dec_vld && $stable(dec_ctl))
    else $error("stalled decode stage lost its word");

endmodule
